/* design/scrolling_led_matrix_text_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scrolling LED matrix text block
// Implication checks sampled on the rising clock edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_LED_MATRIX_TEXT_MACROS_SVH
`define SCROLLING_LED_MATRIX_TEXT_MACROS_SVH

// same-cycle implication
`define SLMT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLMT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/slmt_pkg.sv */
// ----------------------------------------------------------------------------
// slmt_pkg
// Types, widths and the 3x5 font shared by the scrolling LED matrix text block.
// ----------------------------------------------------------------------------
`default_nettype none

package slmt_pkg;

   localparam int CHAR_W        = 8;
   localparam int LEN_W         = 6;
   localparam int MAX_MSG_CHARS = 63;
   localparam int PERIOD_W      = 10;
   localparam int PERIOD_RESET  = 300;
   localparam int IDX_W         = 4;
   localparam int SEL_W         = 10;
   localparam int ROW_W         = 5;
   localparam int GLYPH_W       = 3 * ROW_W;
   localparam int RSP_FIELDS_W  = IDX_W + SEL_W + ROW_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   function automatic logic [GLYPH_W-1:0] glyph(input logic [ROW_W-1:0] c0,
                                                 input logic [ROW_W-1:0] c1,
                                                 input logic [ROW_W-1:0] c2);
      return {c2, c1, c0};
   endfunction

   // three font columns of a character, left column in the low bits
   function automatic logic [GLYPH_W-1:0] font_cols(input logic [CHAR_W-1:0] code);
      logic [GLYPH_W-1:0] g;
      unique case (code)
         8'h79:        g = glyph(5'h03, 5'h1C, 5'h03);  // y
         8'h72:        g = glyph(5'h1F, 5'h05, 5'h1B);  // r
         8'h75, 8'hC8: g = glyph(5'h0F, 5'h10, 5'h1F);  // u, Cyrillic I
         8'h74, 8'hD2: g = glyph(5'h01, 5'h1F, 5'h01);  // t, Cyrillic T
         8'h61:        g = glyph(5'h1E, 5'h05, 5'h1E);  // a
         8'h64:        g = glyph(5'h1F, 5'h11, 5'h0E);  // d
         8'h68, 8'hCD: g = glyph(5'h1F, 5'h04, 5'h1F);  // h, Cyrillic N
         8'h65, 8'hC5: g = glyph(5'h1F, 5'h15, 5'h15);  // e, Cyrillic E
         8'h6C:        g = glyph(5'h1F, 5'h10, 5'h10);  // l
         8'h6F:        g = glyph(5'h0E, 5'h11, 5'h0E);  // o
         8'h30:        g = glyph(5'h1F, 5'h11, 5'h1F);
         8'h31:        g = glyph(5'h12, 5'h1F, 5'h10);
         8'h32:        g = glyph(5'h19, 5'h15, 5'h13);
         8'h33:        g = glyph(5'h15, 5'h15, 5'h1F);
         8'h34:        g = glyph(5'h07, 5'h04, 5'h1F);
         8'h35:        g = glyph(5'h17, 5'h15, 5'h1D);
         8'h36:        g = glyph(5'h1F, 5'h15, 5'h1D);
         8'h37:        g = glyph(5'h19, 5'h05, 5'h03);
         8'h38:        g = glyph(5'h1F, 5'h15, 5'h1F);
         8'h39:        g = glyph(5'h17, 5'h15, 5'h1F);
         8'h21:        g = glyph(5'h00, 5'h17, 5'h00);  // !
         8'h3A:        g = glyph(5'h00, 5'h0A, 5'h00);  // :
         8'hCF:        g = glyph(5'h1F, 5'h01, 5'h1F);  // Cyrillic P
         8'hD0:        g = glyph(5'h1F, 5'h05, 5'h07);  // Cyrillic R
         8'hC2:        g = glyph(5'h1F, 5'h15, 5'h0E);  // Cyrillic V
         8'h2C:        g = glyph(5'h00, 5'h0C, 5'h1C);  // comma
         8'hC3:        g = glyph(5'h1F, 5'h01, 5'h01);  // Cyrillic G
         8'h29:        g = glyph(5'h11, 5'h11, 5'h0E);  // )
         8'h2D:        g = glyph(5'h04, 5'h04, 5'h04);  // -
         8'h6B:        g = glyph(5'h1F, 5'h04, 5'h0A);  // k
         default:      g = '0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

/* design/scrolling_led_matrix_text.sv */
// ----------------------------------------------------------------------------
// scrolling_led_matrix_text
// Marquee controller for a 5-row LED matrix: font lookup, column store, scroll.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a stalled response holds req_tready low.
// A load request (tuser 0) turns its character through the 3x5 font into one
// store row of three columns (the spacer column is implied) and gives no
// response; tlast on a load taken while idle starts the scroll. A tick request
// (tuser 1) gives one response, through the registered read of the column store
// and then the output register. Loads and ticks can be mixed back to back at
// full rate; the single RAM port pair (one row write per load, one row read per
// tick) sets that figure. The store needs no clearing pass after reset: only
// rows of the current message ever reach a response.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_led_matrix_text #(
   parameter int STORE_COLUMNS   = 128,
   parameter int DISPLAY_COLUMNS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slmt_pkg::CHAR_W-1:0]       req_tdata,   // [7:0] char_code
   input  logic                              req_tlast,   // last_char
   input  logic                              req_tuser,   // [0] opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] column_index, [13:4] column_select, [18:14] row_pattern, rest zero
   output logic [slmt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,   // message_done
   output logic                              rsp_tuser,   // [0] scrolling
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slmt_pkg::PERIOD_W-1:0]     csr_data     // scroll_period
);

   import slmt_pkg::*;

   `include "scrolling_led_matrix_text_macros.svh"

   localparam int MAX_CHARS = (STORE_COLUMNS / 4 < MAX_MSG_CHARS) ?
                              STORE_COLUMNS / 4 : MAX_MSG_CHARS;
   localparam int ADDR_W    = $clog2(MAX_CHARS);
   localparam int COL_W     = $clog2(DISPLAY_COLUMNS);
   localparam int OFS_W     = $clog2(4 * MAX_CHARS + DISPLAY_COLUMNS + 1) + 1;
   localparam int POS_W     = OFS_W + 1;
   localparam logic signed [OFS_W-1:0] OFS_RESET = OFS_W'(-DISPLAY_COLUMNS);

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             hit;
      logic [1:0]       sub;
      logic             done;
      logic             active;
   } rd_stage_type;

   // control state
   logic [PERIOD_W-1:0]     period_ff;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic signed [OFS_W-1:0] ofs_ff, ofs_in;
   logic [PERIOD_W-1:0]     cnt_ff, cnt_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic                    act_ff, act_in;

   // read stage and output register
   logic                    s1_valid_ff, s1_valid_in;
   rd_stage_type            s1_ff;
   logic                    out_valid_ff;
   logic [IDX_W-1:0]        out_idx_ff;
   logic [SEL_W-1:0]        out_sel_ff;
   logic [ROW_W-1:0]        out_row_ff;
   logic                    out_done_ff;
   logic                    out_act_ff;

   logic                    s1_move;
   logic                    req_acc, load_acc, tick_acc;
   logic                    tick_done;
   logic                    wr_en;
   logic [LEN_W+1:0]        len4;
   logic signed [POS_W-1:0] pos;
   logic                    pos_hit;
   logic signed [OFS_W-1:0] end_ofs;
   logic [GLYPH_W-1:0]      rd_data;
   logic [ROW_W-1:0]        row_sel;
   logic [SEL_W-1:0]        sel_onehot;

   assign s1_move    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_acc    = req_tvalid && req_tready;
   assign load_acc   = req_acc && (opcode_type'(req_tuser) == OP_LOAD);
   assign tick_acc   = req_acc && (opcode_type'(req_tuser) == OP_TICK);
   assign csr_ready  = 1'b1;

   // column position under the current sweep column
   assign len4    = {len_ff, 2'b00};
   assign pos     = POS_W'($signed({1'b0, col_ff})) + POS_W'(ofs_ff);
   assign pos_hit = !pos[POS_W-1] && ($unsigned(pos) < POS_W'(len4));
   assign end_ofs = OFS_W'(len4) + OFS_W'(DISPLAY_COLUMNS);

   always_comb begin
      len_in    = len_ff;
      ofs_in    = ofs_ff;
      cnt_in    = cnt_ff;
      col_in    = col_ff;
      act_in    = act_ff;
      wr_en     = 1'b0;
      tick_done = 1'b0;
      // loads during a scroll are dropped, tlast included
      if (load_acc && !act_ff) begin
         if (len_ff < LEN_W'(MAX_CHARS)) begin
            wr_en  = 1'b1;
            len_in = len_ff + LEN_W'(1);
         end
         if (req_tlast) begin
            act_in = 1'b1;
            ofs_in = OFS_RESET;
            cnt_in = '0;
            col_in = '0;
         end
      end
      if (tick_acc) begin
         col_in = (col_ff == COL_W'(DISPLAY_COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
         if (act_ff) begin
            if (cnt_ff == period_ff) begin
               cnt_in = '0;
               if (ofs_ff == end_ofs) begin
                  tick_done = 1'b1;
                  act_in    = 1'b0;
                  ofs_in    = OFS_RESET;
                  len_in    = '0;
               end else begin
                  ofs_in = ofs_ff + OFS_W'(1);
               end
            end else begin
               cnt_in = cnt_ff + PERIOD_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_W'(PERIOD_RESET);
         len_ff    <= '0;
         ofs_ff    <= OFS_RESET;
         cnt_ff    <= '0;
         col_ff    <= '0;
         act_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            period_ff <= csr_data;
         end
         len_ff <= len_in;
         ofs_ff <= ofs_in;
         cnt_ff <= cnt_in;
         col_ff <= col_in;
         act_ff <= act_in;
      end
   end

   // a load writes only while idle; a tick reads on every tick but its data is used
   // only while scrolling, so a used read never meets a write to the same row in flight
   slmt_ram #(
      .WIDTH (GLYPH_W),
      .DEPTH (MAX_CHARS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (font_cols(req_tdata)),
      .rd_en   (tick_acc),
      .rd_addr (pos[ADDR_W+1:2]),
      .rd_data (rd_data)
   );

   assign s1_valid_in = tick_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_move) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_acc) begin
         s1_ff.col    <= col_ff;
         s1_ff.hit    <= act_ff && pos_hit;
         s1_ff.sub    <= pos[1:0];
         s1_ff.done   <= tick_done;
         s1_ff.active <= act_ff;
      end
   end

   // fourth column of each character is the blank spacer
   always_comb begin
      unique case (s1_ff.sub)
         2'd0:    row_sel = rd_data[ROW_W-1:0];
         2'd1:    row_sel = rd_data[2*ROW_W-1:ROW_W];
         2'd2:    row_sel = rd_data[3*ROW_W-1:2*ROW_W];
         default: row_sel = '0;
      endcase
      for (int i = 0; i < SEL_W; i++) begin
         sel_onehot[i] = (int'(s1_ff.col) == i);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_idx_ff  <= IDX_W'(s1_ff.col);
         out_sel_ff  <= sel_onehot;
         out_row_ff  <= s1_ff.hit ? row_sel : '0;
         out_done_ff <= s1_ff.done;
         out_act_ff  <= s1_ff.active;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_row_ff, out_sel_ff, out_idx_ff});
   assign rsp_tlast  = out_done_ff;
   assign rsp_tuser  = out_act_ff;

   `SLMT_ASSERT_IMP(a_done_while_scrolling, clock, reset,
      out_valid_ff && out_done_ff, out_act_ff,
      "message done reported outside a scroll")
   `SLMT_ASSERT_IMP(a_idle_offset, clock, reset,
      !act_ff, ofs_ff == OFS_RESET,
      "scroll offset moved while idle")
   `SLMT_ASSERT_IMP(a_len_bound, clock, reset,
      1'b1, len_ff <= LEN_W'(MAX_CHARS),
      "message length past store capacity")
   `SLMT_ASSERT_NXT(a_load_ignored, clock, reset,
      load_acc && act_ff, $stable(len_ff) && act_ff,
      "load changed state during a scroll")
   `SLMT_ASSERT_IMP(a_no_overrun, clock, reset,
      tick_acc && s1_valid_ff, s1_move,
      "tick taken over a stalled read stage")

endmodule

`default_nettype wire

/* design/slmt_ram.sv */
// ----------------------------------------------------------------------------
// slmt_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slmt_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: scrolling LED matrix marquee testbench
// Drives character loads and refresh ticks into the marquee and checks every
// column drive against an in-bench model of the font, the store and the
// scroll counters. Short directed table first, then random messages with
// bursty requests, receiver stalls and changes of the scroll period.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import slmt_pkg::*;

   localparam int STORE_COLS   = 128;
   localparam int DISP_COLS    = 10;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic [3:0] idx;
      logic [9:0] sel;
      logic [4:0] row;
      logic       done;
      logic       active;
   } column_drive_type;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      opcode_type       op;
      logic [7:0]       code;
      logic             last;
      logic [9:0]       period;
      logic             typed;
      column_drive_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [PERIOD_W-1:0]   csr_data   = '0;

   scrolling_led_matrix_text DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // marquee model state
   logic [4:0]  led_columns [STORE_COLS];
   int          text_len     = 0;
   int          scroll_pos   = -DISP_COLS;
   logic [9:0]  refresh_ticks = '0;
   int          sweep_col    = 0;
   bit          marquee_on   = 1'b0;
   logic [9:0]  shift_period = 10'd300;

   column_drive_type expected_drives [$];
   stim_row_type     stim_table [$];

   int  mismatches     = 0;
   int  items_taken    = 0;
   int  item_goal      = 0;
   int  ticks_sent     = 0;
   int  drives_checked = 0;
   int  messages_done  = 0;
   int  chars_dropped  = 0;
   int  period_writes  = 0;
   int  burst_left     = 0;
   bit  steady         = 1'b0;
   int  cycle_count    = 0;

   logic [7:0] rx_pattern = 8'hFF;
   logic [5:0] rx_phase   = '0;

   function automatic int font_index(input logic [7:0] code);
      case (code)
         "y": return 30;  "r": return 7;   "u": return 23;  "t": return 25;
         "a": return 5;   "d": return 6;   "h": return 1;   "e": return 2;
         "l": return 3;   "o": return 4;   "0": return 17;  "1": return 8;
         "2": return 9;   "3": return 10;  "4": return 11;  "5": return 12;
         "6": return 13;  "7": return 14;  "8": return 15;  "9": return 16;
         "!": return 19;  ":": return 18;  8'hCF: return 21; 8'hD0: return 22;
         8'hC8: return 23; 8'hC2: return 24; 8'hC5: return 2; 8'hD2: return 25;
         ",": return 26;  8'hC3: return 27; 8'hCD: return 1;  ")": return 28;
         "-": return 29;  "k": return 20;
         default: return 0;
      endcase
   endfunction

   // {third, second, first} column
   function automatic logic [14:0] glyph_bits(input int idx);
      case (idx)
         1:  return {5'h1F, 5'h04, 5'h1F};
         2:  return {5'h15, 5'h15, 5'h1F};
         3:  return {5'h10, 5'h10, 5'h1F};
         4:  return {5'h0E, 5'h11, 5'h0E};
         5:  return {5'h1E, 5'h05, 5'h1E};
         6:  return {5'h0E, 5'h11, 5'h1F};
         7:  return {5'h1B, 5'h05, 5'h1F};
         8:  return {5'h10, 5'h1F, 5'h12};
         9:  return {5'h13, 5'h15, 5'h19};
         10: return {5'h1F, 5'h15, 5'h15};
         11: return {5'h1F, 5'h04, 5'h07};
         12: return {5'h1D, 5'h15, 5'h17};
         13: return {5'h1D, 5'h15, 5'h1F};
         14: return {5'h03, 5'h05, 5'h19};
         15: return {5'h1F, 5'h15, 5'h1F};
         16: return {5'h1F, 5'h15, 5'h17};
         17: return {5'h1F, 5'h11, 5'h1F};
         18: return {5'h00, 5'h0A, 5'h00};
         19: return {5'h00, 5'h17, 5'h00};
         20: return {5'h0A, 5'h04, 5'h1F};
         21: return {5'h1F, 5'h01, 5'h1F};
         22: return {5'h07, 5'h05, 5'h1F};
         23: return {5'h1F, 5'h10, 5'h0F};
         24: return {5'h0E, 5'h15, 5'h1F};
         25: return {5'h01, 5'h1F, 5'h01};
         26: return {5'h1C, 5'h0C, 5'h00};
         27: return {5'h01, 5'h01, 5'h1F};
         28: return {5'h0E, 5'h11, 5'h11};
         29: return {5'h04, 5'h04, 5'h04};
         30: return {5'h03, 5'h1C, 5'h03};
         default: return '0;
      endcase
   endfunction

   function automatic logic [7:0] pick_char();
      logic [7:0] known [34];
      known = '{"y", "r", "u", "t", "a", "d", "h", "e", "l", "o",
                "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                "!", ":", 8'hCF, 8'hD0, 8'hC8, 8'hC2, 8'hC5, 8'hD2,
                ",", 8'hC3, 8'hCD, ")", "-", "k"};
      if ($urandom_range(0, 1) == 0)
         return known[$urandom_range(0, 33)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic column_drive_type drive_of(input int idx, input logic [4:0] row,
                                                 input bit done, input bit active);
      column_drive_type d;
      d.idx    = 4'(idx);
      d.sel    = 10'(1 << idx);
      d.row    = row;
      d.done   = done;
      d.active = active;
      return d;
   endfunction

   task automatic advance_marquee(input opcode_type op, input logic [7:0] code,
                                  input bit last, output bit ignored,
                                  output bit has_drive, output column_drive_type drive);
      int          pos;
      int          base;
      logic [14:0] g;
      ignored   = 1'b0;
      has_drive = 1'b0;
      drive     = '0;
      if (op == OP_LOAD) begin
         if (marquee_on) begin
            ignored = 1'b1;
            return;
         end
         if (text_len < MAX_MSG_CHARS && (text_len + 1) * 4 <= STORE_COLS) begin
            g    = glyph_bits(font_index(code));
            base = text_len * 4;
            led_columns[base]     = g[4:0];
            led_columns[base + 1] = g[9:5];
            led_columns[base + 2] = g[14:10];
            led_columns[base + 3] = '0;
            text_len++;
         end else begin
            chars_dropped++;
         end
         if (last) begin
            marquee_on    = 1'b1;
            scroll_pos    = -DISP_COLS;
            refresh_ticks = '0;
            sweep_col     = 0;
         end
         return;
      end
      has_drive = 1'b1;
      drive     = drive_of(sweep_col, 5'd0, 1'b0, marquee_on);
      if (marquee_on) begin
         pos = sweep_col + scroll_pos;
         if (pos >= 0 && pos < text_len * 4 && pos < STORE_COLS)
            drive.row = led_columns[pos];
         if (refresh_ticks == shift_period) begin
            refresh_ticks = '0;
            if (scroll_pos == text_len * 4 + DISP_COLS) begin
               drive.done = 1'b1;
               marquee_on = 1'b0;
               scroll_pos = -DISP_COLS;
               text_len   = 0;
               messages_done++;
            end else begin
               scroll_pos++;
            end
         end else begin
            refresh_ticks = refresh_ticks + 10'd1;
         end
      end
      sweep_col = (sweep_col + 1 >= DISP_COLS) ? 0 : sweep_col + 1;
   endtask

   task automatic send_request(input opcode_type op, input logic [7:0] code,
                               input bit last, input bit typed,
                               input column_drive_type want);
      int               gap;
      bit               ignored;
      bit               has_drive;
      column_drive_type drive;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= last;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      advance_marquee(op, code, last, ignored, has_drive, drive);
      if (!ignored)
         items_taken++;
      if (has_drive) begin
         expected_drives.push_back(typed ? want : drive);
         ticks_sent++;
      end
   endtask

   task automatic tick();
      send_request(OP_TICK, pick_char(), 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   // drop valid, let all responses come back, then cover the response latency
   task automatic settle();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [9:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shift_period = value;
      period_writes++;
   endtask

   task automatic run_message(input int cap);
      int n;
      int k;
      bit flag_last;
      if (!marquee_on) begin
         repeat ($urandom_range(0, 3)) tick();
         n = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 4);
         // now and then the last flag is missing and the text runs on
         flag_last = ($urandom_range(0, 7) != 0);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 5) == 0)
               tick();
            send_request(OP_LOAD, pick_char(), flag_last && k == n - 1, 1'b0, '0);
         end
      end
      k = 0;
      while (marquee_on && k < cap && items_taken < item_goal) begin
         if ($urandom_range(0, 9) == 0)
            send_request(OP_LOAD, pick_char(), 1'($urandom_range(0, 1)), 1'b0, '0);
         else
            tick();
         k++;
      end
      repeat ($urandom_range(1, 3)) tick();
   endtask

   function automatic stim_row_type req_row(input opcode_type op, input logic [7:0] code,
                                            input bit last, input bit typed,
                                            input column_drive_type want);
      stim_row_type r;
      r        = '0;
      r.kind   = ROW_REQ;
      r.op     = op;
      r.code   = code;
      r.last   = last;
      r.typed  = typed;
      r.want   = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [9:0] value);
      stim_row_type r;
      r        = '0;
      r.kind   = ROW_CSR;
      r.op     = OP_TICK;
      r.period = value;
      return r;
   endfunction

   // receiver stall pattern, reshuffled each time the 6-bit phase counter wraps
   always @(posedge clock) begin
      rx_phase <= rx_phase + 6'd1;
      if (rx_phase == 6'd63)
         rx_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF
                                                   : (8'($urandom_range(0, 255)) | 8'h01);
      rsp_tready <= rx_pattern[rx_phase[2:0]];
   end

   task automatic flag_field(input string name, input int want, input int got);
      if (mismatches < 10)
         $display("column drive %0d: %s expected %0d, got %0d",
                  drives_checked, name, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      column_drive_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drives.size() == 0) begin
            if (mismatches < 10)
               $display("column drive with nothing pending: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_tdata[3:0] !== want.idx)
               flag_field("column_index", int'(want.idx), int'(rsp_tdata[3:0]));
            if (rsp_tdata[13:4] !== want.sel)
               flag_field("column_select", int'(want.sel), int'(rsp_tdata[13:4]));
            if (rsp_tdata[18:14] !== want.row)
               flag_field("row_pattern", int'(want.row), int'(rsp_tdata[18:14]));
            if (rsp_tlast !== want.done)
               flag_field("message_done", int'(want.done), int'(rsp_tlast));
            if (rsp_tuser !== want.active)
               flag_field("scrolling", int'(want.active), int'(rsp_tuser));
            drives_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("scrolling_led_matrix_text: mismatch");
         $finish;
      end
   end

   initial begin
      int phase;
      int start_items;
      int i;
      stim_row_type r;

      // reset period, idle sweep
      stim_table.push_back(req_row(OP_TICK, 8'h00, 1'b0, 1'b1,
                                   drive_of(0, 5'd0, 1'b0, 1'b0)));
      stim_table.push_back(req_row(OP_TICK, 8'hFF, 1'b1, 1'b1,
                                   drive_of(1, 5'd0, 1'b0, 1'b0)));
      stim_table.push_back(req_row(OP_LOAD, "h", 1'b0, 1'b0, '0));
      stim_table.push_back(req_row(OP_LOAD, 8'h00, 1'b0, 1'b0, '0));   // unknown, blank
      stim_table.push_back(req_row(OP_TICK, 8'h00, 1'b0, 1'b1,
                                   drive_of(2, 5'd0, 1'b0, 1'b0)));
      stim_table.push_back(req_row(OP_LOAD, 8'hFF, 1'b0, 1'b0, '0));   // unknown, blank
      stim_table.push_back(req_row(OP_LOAD, 8'hCF, 1'b0, 1'b0, '0));
      stim_table.push_back(req_row(OP_LOAD, 8'hC5, 1'b1, 1'b0, '0));   // starts scroll
      stim_table.push_back(req_row(OP_LOAD, "e", 1'b1, 1'b0, '0));     // ignored
      stim_table.push_back(req_row(OP_TICK, 8'h00, 1'b0, 1'b1,
                                   drive_of(0, 5'd0, 1'b0, 1'b1)));
      stim_table.push_back(req_row(OP_TICK, 8'h00, 1'b0, 1'b0, '0));
      stim_table.push_back(csr_row(10'd2));
      for (i = 0; i < 10; i++)
         stim_table.push_back(req_row(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0));
      stim_table.push_back(req_row(OP_LOAD, 8'h80, 1'b1, 1'b0, '0));   // ignored

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[j]) begin
         r = stim_table[j];
         if (r.kind == ROW_CSR) begin
            settle();
            write_period(r.period);
         end else begin
            send_request(r.op, r.code, r.last, r.typed, r.want);
         end
      end

      start_items = items_taken;
      item_goal   = start_items + RANDOM_ITEMS;
      phase = 0;
      while (items_taken - start_items < RANDOM_ITEMS) begin
         settle();
         if (phase == 2) begin
            // count climbs under a long period, then the period drops below it
            write_period(10'd1023);
            run_message(60);
            settle();
            write_period(10'd2);
            steady = 1'b0;
            run_message(1200);
         end else begin
            if (phase == 0)
               write_period(10'd1);
            else if ($urandom_range(0, 9) < 6)
               write_period(10'($urandom_range(1, 3)));
            else
               write_period(10'($urandom_range(4, 12)));
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) run_message(400);
         end
         phase++;
      end

      settle();
      $display("%0d requests (%0d ticks), %0d column drives checked, %0d period writes",
               items_taken, ticks_sent, drives_checked, period_writes);
      $display("%0d messages scrolled out, %0d characters dropped on a full store",
               messages_done, chars_dropped);
      if (mismatches == 0 && expected_drives.size() == 0) begin
         $display("scrolling_led_matrix_text: match");
      end else begin
         $display("scrolling_led_matrix_text: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/slmt_pkg.sv
design/slmt_ram.sv
design/scrolling_led_matrix_text.sv
sim/tb_top.sv
